// ===== rtl/osdt_pkg.sv =====
// Package with the shared types and operation codes of the decision tree evaluator.
`timescale 1ns / 1ps
`default_nettype none

package osdt_pkg;

    // Field widths of one transaction.
    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int NODE_IN_W = 7;
    localparam int SLOT_IN_W = 3;

    // Slot operation codes; codes 6 and 7 leave the value unchanged.
    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_ANDN   = 3'd1;
    localparam logic [OP_W-1:0] OP_XOR    = 3'd2;
    localparam logic [OP_W-1:0] OP_LSL    = 3'd3;
    localparam logic [OP_W-1:0] OP_LSR    = 3'd4;
    localparam logic [OP_W-1:0] OP_ASSIGN = 3'd5;

    // Command actions.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    // One stored slot: an operation code and its operand.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] operand;
    } slot_t;

    // Command transaction.
    typedef struct packed {
        logic                 action;
        logic [NODE_IN_W-1:0] node_index;
        logic [SLOT_IN_W-1:0] slot_index;
        logic [OP_W-1:0]      op_code;
        logic [BYTE_W-1:0]    operand_value;
        logic [BYTE_W-1:0]    symbol_byte;
    } cmd_item_t;

    // Result transaction.
    typedef struct packed {
        logic [BYTE_W-1:0] class_byte;
        logic              walk_error;
    } res_item_t;

endpackage

`default_nettype wire

// ===== rtl/osdt_cmd_if.sv =====
// Interface of the command channel.
`timescale 1ns / 1ps
`default_nettype none

interface osdt_cmd_if;
    import osdt_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/osdt_res_if.sv =====
// Interface of the result channel.
`timescale 1ns / 1ps
`default_nettype none

interface osdt_res_if;
    import osdt_pkg::*;

    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/op_sequence_decision_tree_eval_core.sv =====
// Top level of the decision tree byte classifier: sequencer, slot memory and slot unit.
//
// Usage. The cmd channel takes write and evaluate transactions; the res channel
// returns one transaction per evaluate and none per write. Both use valid/ready.
// After reset the slot memory is cleared one entry per cycle over all NODES*SLOTS
// entries (640 at the defaults); cmd.ready stays low while the sweep runs.
// A write goes to memory as it is accepted; an out-of-range node or slot is dropped.
// An evaluate walks the tree from node 1. Each inner node reads its last slot,
// tests it, runs the slots one per cycle through the single slot unit, and
// then forms the child index. The memory read port sets that pace. A leaf is
// read and tested, and its result is then handed to the output register.
// A child index past the table ends the walk with walk_error set and a zero
// class byte. The block takes one evaluate at a time and is ready again once
// its result sits in the output register.
// A stalled receiver holds the output register; a finished walk then waits
// until that register frees before the next command is taken.
`timescale 1ns / 1ps
`default_nettype none

module op_sequence_decision_tree_eval_core #(
    parameter int NODES = 128,
    parameter int SLOTS = 5
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    osdt_cmd_if.sink    cmd,
    osdt_res_if.source  res
);
    import osdt_pkg::*;

    localparam int DEPTH = NODES * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(NODES);
    localparam int SW    = $clog2(SLOTS);
    localparam int CHW   = NW + BYTE_W + 1;
    localparam int SLW   = $bits(slot_t);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOOK  = 7'b0000100,
        S_LEAF  = 7'b0001000,
        S_RUN   = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [NW-1:0]     node_reg, node_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [BYTE_W-1:0] sym_reg, sym_next;
    logic [BYTE_W-1:0] val_reg, val_next;
    res_item_t         pend_reg, pend_next;
    logic              res_valid_reg, res_valid_next;
    res_item_t         res_data_reg, res_data_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [SLW-1:0]    wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [SLW-1:0]    rd_raw;
    slot_t             rd_slot;
    logic [BYTE_W-1:0] alu_result;
    logic [CHW-1:0]    child;
    logic              cmd_fire;
    logic              wr_in_range;
    logic              out_free;
    logic              clr_last;

    assign rd_slot = slot_t'(rd_raw);

    // Slot memory, cleared by a sweep after reset.
    osdt_ram #(
        .WIDTH (SLW),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // The one slot unit, fed from the read port and the running byte.
    osdt_slot_alu u_alu (
        .value  (val_reg),
        .slot   (rd_slot),
        .result (alu_result)
    );

    assign cmd.ready   = (state_reg == S_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign wr_in_range = (32'(cmd.data.node_index) < NODES)
                      && (32'(cmd.data.slot_index) < SLOTS);
    assign out_free    = !res_valid_reg || res.ready;
    assign clr_last    = (clr_addr_reg == AW'(DEPTH - 1));
    assign child       = CHW'({node_reg, 1'b0}) + CHW'(val_reg);

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    // Memory write port: clearing sweep, or a slot write from the command channel.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = cmd_fire && (cmd.data.action == ACT_WRITE) && wr_in_range;
            wr_addr = AW'(32'(cmd.data.node_index) * SLOTS + 32'(cmd.data.slot_index));
            wr_data = {cmd.data.op_code, cmd.data.operand_value};
        end
    end

    // Walk sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        node_next      = node_reg;
        base_next      = base_reg;
        slot_next      = slot_reg;
        sym_next       = sym_reg;
        val_next       = val_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        rd_en          = 1'b0;
        rd_addr        = base_reg + AW'(SLOTS - 1);

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_fire && (cmd.data.action == ACT_EVAL))
                begin
                    sym_next   = cmd.data.symbol_byte;
                    node_next  = NW'(1);
                    base_next  = AW'(SLOTS);
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                // Fetch the node's last slot to tell leaf from inner node.
                rd_en      = 1'b1;
                rd_addr    = base_reg + AW'(SLOTS - 1);
                state_next = S_LEAF;
            end
            S_LEAF:
            begin
                if (rd_slot.op == OP_ASSIGN)
                begin
                    pend_next.class_byte = rd_slot.operand;
                    pend_next.walk_error = 1'b0;
                    state_next           = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = base_reg;
                    slot_next  = '0;
                    val_next   = sym_reg;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                // One slot per cycle; the next slot's read overlaps this one.
                val_next = alu_result;
                if (slot_reg == SW'(SLOTS - 1))
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = base_reg + AW'(slot_reg) + 1'b1;
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_NEXT:
            begin
                if (child >= CHW'(NODES))
                begin
                    pend_next.class_byte = '0;
                    pend_next.walk_error = 1'b1;
                    state_next           = S_DONE;
                end
                else
                begin
                    node_next  = child[NW-1:0];
                    base_next  = AW'(32'(child[NW-1:0]) * SLOTS);
                    state_next = S_LOOK;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        base_reg     <= base_next;
        slot_reg     <= slot_next;
        sym_reg      <= sym_next;
        val_reg      <= val_next;
        pend_reg     <= pend_next;
        res_data_reg <= res_data_next;
    end

    // The clearing sweep ends in the idle state.
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_last) |=> (state_reg == S_IDLE))
        else $error("clearing sweep did not end in idle");

    // Every slot of an inner node runs before the child index is formed.
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && slot_reg == SW'(SLOTS - 1)) |=> (state_reg == S_NEXT))
        else $error("slot run did not finish into child step");

    // The walk never visits node zero.
    a_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEAF || state_reg == S_RUN) |-> (node_reg != '0))
        else $error("walk reached node zero");

    // An error result carries a zero class byte.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.walk_error) |-> (res_data_reg.class_byte == '0))
        else $error("error result with nonzero class byte");

endmodule

`default_nettype wire

// ===== rtl/osdt_ram.sv =====
// Generic memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module osdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/osdt_slot_alu.sv =====
// Shared slot unit: applies one slot operation to the running byte.
`timescale 1ns / 1ps
`default_nettype none

module osdt_slot_alu (
    input  wire logic [7:0]     value,
    input  wire osdt_pkg::slot_t slot,
    output logic      [7:0]     result
);
    import osdt_pkg::*;

    logic shift_out;

    // A shift by eight or more clears the byte.
    assign shift_out = (slot.operand[BYTE_W-1:3] != '0);

    always_comb
    begin
        case (slot.op)
            OP_ADD:    result = value + slot.operand;
            OP_ANDN:   result = value & ~slot.operand;
            OP_XOR:    result = value ^ slot.operand;
            OP_LSL:    result = shift_out ? '0 : (value << slot.operand[2:0]);
            OP_LSR:    result = shift_out ? '0 : (value >> slot.operand[2:0]);
            OP_ASSIGN: result = slot.operand;
            default:   result = value;
        endcase
    end

endmodule

`default_nettype wire
